### rtl/first_fit_free_list_allocator_top_defines.svh
// Assertion macros shared by the allocator RTL.
`ifndef FIRST_FIT_FREE_LIST_ALLOCATOR_TOP_DEFINES_SVH
`define FIRST_FIT_FREE_LIST_ALLOCATOR_TOP_DEFINES_SVH

// Check a condition in the same cycle as its trigger.
`define FFA_ASSERT_NOW(lbl, clk_i, rstn_i, ante, cons) \
	lbl: assert property (@(posedge clk_i) disable iff (!rstn_i) (ante) |-> (cons)) \
		else $error("allocator check failed in trigger cycle");

// Check a condition in the cycle after its trigger.
`define FFA_ASSERT_NEXT(lbl, clk_i, rstn_i, ante, cons) \
	lbl: assert property (@(posedge clk_i) disable iff (!rstn_i) (ante) |=> (cons)) \
		else $error("allocator check failed in cycle after trigger");

`endif

### rtl/ffa_pkg.sv
// Types, constants and codes of the first-fit free-region allocator.
package ffa_pkg;

	localparam int MAX_REGIONS = 4096;
	localparam int IDX_W       = $clog2(MAX_REGIONS);
	localparam int CNT_W       = $clog2(MAX_REGIONS + 1);

	localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_REGIONS);

	localparam logic [31:0] PAGE_ADD  = 32'h0000_0fff;
	localparam logic [31:0] PAGE_MASK = 32'hffff_f000;

	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_FREE  = 1'b1;

	typedef enum logic [1:0] {
		ST_DONE  = 2'd0,
		ST_NOFIT = 2'd1,
		ST_LOST  = 2'd2
	} status_t;

	// One table entry: a free region.
	typedef struct packed {
		logic [31:0] start;
		logic [31:0] len;
	} region_t;

	typedef struct packed {
		logic               en;
		logic [IDX_W-1:0]   addr;
		region_t            data;
	} ram_wr_t;

	// Request and response of the shared add/subtract unit.
	typedef struct packed {
		logic [31:0] a;
		logic [31:0] b;
		logic        sub;
	} alu_req_t;

	typedef struct packed {
		logic [31:0] res;
		logic        carry;
		logic        zero;
	} alu_rsp_t;

endpackage

### rtl/ffa_alu.sv
// Shared 32-bit add/subtract unit with carry and zero flags.
module ffa_alu (
	input  ffa_pkg::alu_req_t req,
	output ffa_pkg::alu_rsp_t rsp
);

	logic [32:0] sum;

	// Subtract as add of the inverted operand plus one; carry set means a >= b.
	assign sum = {1'b0, req.a} + {1'b0, req.b ^ {32{req.sub}}} + {32'd0, req.sub};

	assign rsp.res   = sum[31:0];
	assign rsp.carry = sum[32];
	assign rsp.zero  = (sum[31:0] == 32'd0);

endmodule

### rtl/ffa_region_ram.sv
// Region table memory: one write port, one read port with registered data.
module ffa_region_ram (
	input  logic                         clk,
	input  ffa_pkg::ram_wr_t             wr,
	input  logic [ffa_pkg::IDX_W-1:0]    rd_addr,
	output ffa_pkg::region_t             rd_data
);

	ffa_pkg::region_t mem [ffa_pkg::MAX_REGIONS];
	ffa_pkg::region_t rd_data_q;

	// Write and read the table
	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
		rd_data_q <= mem[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule

### rtl/first_fit_free_list_allocator_top.sv
// First-fit free-region allocator: sequencer, region table and shared adder.
//
// A command is taken when start is high and busy is low; one result follows
// with done high for exactly one cycle, and it must be taken then, as the
// receiver cannot stall the block. busy stays high from the command until
// the cycle of the result. Page rounding adds the S_ROUND state in front. An
// allocate scans the table one entry a cycle until the first fit, then steps
// through S_A_START, S_A_LEN and S_A_SUM to update the entry and the free
// total, plus S_RM_START and an S_RM_SHIFT step per entry behind it if the
// region empties and the table closes the gap. A free scans one entry a
// cycle up to its sorted place, then runs merge checks and updates on the
// shared adder, plus a shift of each later entry when a new region opens a
// slot or a double merge closes one. A free that needs a new entry while the
// table is full is counted as lost. The scan and the shift together visit
// each entry once, so the worst case grows with the entry count, set by the
// single read and write port of the table and the one adder. The table needs
// no clearing after reset: only entries below the entry count are ever used.
`include "first_fit_free_list_allocator_top_defines.svh"

module first_fit_free_list_allocator_top (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic                         operation,
	input  logic [31:0]                  block_address,
	input  logic [31:0]                  block_size,
	input  logic                         page_round,
	output logic                         done,
	output logic [31:0]                  result_address,
	output logic [1:0]                   status,
	output logic [31:0]                  free_total,
	output logic [ffa_pkg::CNT_W-1:0]    entry_count,
	output logic [ffa_pkg::CNT_W-1:0]    peak_entry_count,
	output logic [31:0]                  lost_count,
	output logic [31:0]                  lost_bytes
);

	typedef enum logic [24:0] {
		S_IDLE      = 25'b1 << 0,
		S_ROUND     = 25'b1 << 1,
		S_SCAN0     = 25'b1 << 2,
		S_SCAN      = 25'b1 << 3,
		S_A_START   = 25'b1 << 4,
		S_A_LEN     = 25'b1 << 5,
		S_A_SUM     = 25'b1 << 6,
		S_F_PSUM    = 25'b1 << 7,
		S_F_PEQ     = 25'b1 << 8,
		S_F_NSUM    = 25'b1 << 9,
		S_F_NEQ     = 25'b1 << 10,
		S_F_MNEXT   = 25'b1 << 11,
		S_F_MPREV   = 25'b1 << 12,
		S_F_MPSUM   = 25'b1 << 13,
		S_F_MPEQ    = 25'b1 << 14,
		S_F_JOIN    = 25'b1 << 15,
		S_F_SUM     = 25'b1 << 16,
		S_F_INS     = 25'b1 << 17,
		S_INS_SHIFT = 25'b1 << 18,
		S_INS_WRITE = 25'b1 << 19,
		S_L_CNT     = 25'b1 << 20,
		S_L_BYTES   = 25'b1 << 21,
		S_RM_START  = 25'b1 << 22,
		S_RM_SHIFT  = 25'b1 << 23,
		S_DONE      = 25'b1 << 24
	} state_t;

	localparam int CW = ffa_pkg::CNT_W;
	localparam int IW = ffa_pkg::IDX_W;

	// Control and architectural state
	state_t            state_q, state_d;
	logic [CW-1:0]     count_q, count_d;
	logic [CW-1:0]     peak_q, peak_d;
	logic [31:0]       lost_cnt_q, lost_cnt_d;
	logic [31:0]       lost_bytes_q, lost_bytes_d;
	logic [31:0]       sum_q, sum_d;
	logic              done_q, done_d;

	// Per-command working registers
	logic              op_q, op_d;
	logic [31:0]       addr_q, addr_d;
	logic [31:0]       size_q, size_d;
	logic [CW-1:0]     k_q, k_d;
	logic [CW-1:0]     m_q, m_d;
	ffa_pkg::region_t  cur_q, cur_d;
	ffa_pkg::region_t  prev_q, prev_d;
	logic [31:0]       tmp_q, tmp_d;
	logic [31:0]       res_addr_q, res_addr_d;
	ffa_pkg::status_t  status_q, status_d;
	logic              rm_q, rm_d;

	ffa_pkg::alu_req_t alu_req;
	ffa_pkg::alu_rsp_t alu_rsp;
	ffa_pkg::ram_wr_t  ram_wr;
	logic [IW-1:0]     rd_addr;
	ffa_pkg::region_t  rd_data;

	logic [CW-1:0]     k_inc, k_dec, m_inc, m_inc2, m_dec, m_dec2, cnt_inc, cnt_dec;
	logic              has_next;

	ffa_alu u_alu (
		.req (alu_req),
		.rsp (alu_rsp)
	);

	ffa_region_ram u_ram (
		.clk     (clk),
		.wr      (ram_wr),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// Index arithmetic for the scan and shift pointers
	assign k_inc    = k_q + CW'(1);
	assign k_dec    = k_q - CW'(1);
	assign m_inc    = m_q + CW'(1);
	assign m_inc2   = m_q + CW'(2);
	assign m_dec    = m_q - CW'(1);
	assign m_dec2   = m_q - CW'(2);
	assign cnt_inc  = count_q + CW'(1);
	assign cnt_dec  = count_q - CW'(1);
	assign has_next = (k_q != count_q);

	// Sequence one command through the table and the shared adder
	always_comb begin
		state_d      = state_q;
		count_d      = count_q;
		peak_d       = peak_q;
		lost_cnt_d   = lost_cnt_q;
		lost_bytes_d = lost_bytes_q;
		sum_d        = sum_q;
		done_d       = 1'b0;
		op_d         = op_q;
		addr_d       = addr_q;
		size_d       = size_q;
		k_d          = k_q;
		m_d          = m_q;
		cur_d        = cur_q;
		prev_d       = prev_q;
		tmp_d        = tmp_q;
		res_addr_d   = res_addr_q;
		status_d     = status_q;
		rm_d         = rm_q;
		alu_req      = '0;
		ram_wr       = '0;
		rd_addr      = '0;

		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					op_d       = operation;
					addr_d     = block_address;
					size_d     = block_size;
					k_d        = '0;
					res_addr_d = '0;
					status_d   = ffa_pkg::ST_DONE;
					rm_d       = 1'b0;
					state_d    = page_round ? S_ROUND : S_SCAN0;
				end
			end
			S_ROUND: begin
				alu_req = '{a: size_q, b: ffa_pkg::PAGE_ADD, sub: 1'b0};
				size_d  = alu_rsp.res & ffa_pkg::PAGE_MASK;
				state_d = S_SCAN0;
			end
			S_SCAN0: begin
				if (count_q == '0) begin
					if (op_q == ffa_pkg::OP_ALLOC) begin
						status_d = ffa_pkg::ST_NOFIT;
						state_d  = S_DONE;
					end else begin
						state_d = S_F_PSUM;
					end
				end else begin
					rd_addr = '0;
					state_d = S_SCAN;
				end
			end
			S_SCAN: begin
				// Read ahead the next entry while testing this one
				rd_addr = k_inc[IW-1:0];
				if (op_q == ffa_pkg::OP_ALLOC) begin
					alu_req = '{a: rd_data.len, b: size_q, sub: 1'b1};
					if (alu_rsp.carry) begin
						cur_d   = rd_data;
						state_d = S_A_START;
					end else if (k_inc == count_q) begin
						status_d = ffa_pkg::ST_NOFIT;
						state_d  = S_DONE;
					end else begin
						k_d = k_inc;
					end
				end else begin
					alu_req = '{a: addr_q, b: rd_data.start, sub: 1'b1};
					if (!alu_rsp.carry) begin
						cur_d   = rd_data;
						state_d = S_F_PSUM;
					end else begin
						prev_d = rd_data;
						k_d    = k_inc;
						if (k_inc == count_q) begin
							state_d = S_F_PSUM;
						end
					end
				end
			end
			S_A_START: begin
				alu_req    = '{a: cur_q.start, b: size_q, sub: 1'b0};
				tmp_d      = alu_rsp.res;
				res_addr_d = cur_q.start;
				state_d    = S_A_LEN;
			end
			S_A_LEN: begin
				alu_req = '{a: cur_q.len, b: size_q, sub: 1'b1};
				ram_wr  = '{en: 1'b1, addr: k_q[IW-1:0],
					data: '{start: tmp_q, len: alu_rsp.res}};
				rm_d    = alu_rsp.zero;
				state_d = S_A_SUM;
			end
			S_A_SUM: begin
				alu_req = '{a: sum_q, b: size_q, sub: 1'b1};
				sum_d   = alu_rsp.res;
				state_d = rm_q ? S_RM_START : S_DONE;
			end
			S_F_PSUM: begin
				if (k_q == '0) begin
					state_d = S_F_NSUM;
				end else begin
					alu_req = '{a: prev_q.start, b: prev_q.len, sub: 1'b0};
					tmp_d   = alu_rsp.res;
					state_d = S_F_PEQ;
				end
			end
			S_F_PEQ: begin
				alu_req = '{a: tmp_q, b: addr_q, sub: 1'b1};
				state_d = alu_rsp.zero ? S_F_MPREV : S_F_NSUM;
			end
			S_F_NSUM: begin
				if (has_next) begin
					alu_req = '{a: addr_q, b: size_q, sub: 1'b0};
					tmp_d   = alu_rsp.res;
					state_d = S_F_NEQ;
				end else begin
					state_d = S_F_INS;
				end
			end
			S_F_NEQ: begin
				alu_req = '{a: tmp_q, b: cur_q.start, sub: 1'b1};
				state_d = alu_rsp.zero ? S_F_MNEXT : S_F_INS;
			end
			S_F_MNEXT: begin
				// Grow the following region downward
				alu_req = '{a: cur_q.len, b: size_q, sub: 1'b0};
				ram_wr  = '{en: 1'b1, addr: k_q[IW-1:0],
					data: '{start: addr_q, len: alu_rsp.res}};
				state_d = S_F_SUM;
			end
			S_F_MPREV: begin
				// Grow the preceding region upward
				alu_req     = '{a: prev_q.len, b: size_q, sub: 1'b0};
				prev_d.len  = alu_rsp.res;
				ram_wr      = '{en: 1'b1, addr: k_dec[IW-1:0],
					data: '{start: prev_q.start, len: alu_rsp.res}};
				state_d     = has_next ? S_F_MPSUM : S_F_SUM;
			end
			S_F_MPSUM: begin
				alu_req = '{a: addr_q, b: size_q, sub: 1'b0};
				tmp_d   = alu_rsp.res;
				state_d = S_F_MPEQ;
			end
			S_F_MPEQ: begin
				alu_req = '{a: tmp_q, b: cur_q.start, sub: 1'b1};
				state_d = alu_rsp.zero ? S_F_JOIN : S_F_SUM;
			end
			S_F_JOIN: begin
				// Absorb the following region and drop its entry
				alu_req = '{a: prev_q.len, b: cur_q.len, sub: 1'b0};
				ram_wr  = '{en: 1'b1, addr: k_dec[IW-1:0],
					data: '{start: prev_q.start, len: alu_rsp.res}};
				rm_d    = 1'b1;
				state_d = S_F_SUM;
			end
			S_F_SUM: begin
				alu_req = '{a: sum_q, b: size_q, sub: 1'b0};
				sum_d   = alu_rsp.res;
				state_d = rm_q ? S_RM_START : S_DONE;
			end
			S_F_INS: begin
				if (count_q == ffa_pkg::MAX_CNT) begin
					state_d = S_L_CNT;
				end else if (k_q == count_q) begin
					state_d = S_INS_WRITE;
				end else begin
					rd_addr = cnt_dec[IW-1:0];
					m_d     = count_q;
					state_d = S_INS_SHIFT;
				end
			end
			S_INS_SHIFT: begin
				// Move entry m-1 up to m, reading the one below it
				ram_wr = '{en: 1'b1, addr: m_q[IW-1:0], data: rd_data};
				if (m_dec == k_q) begin
					state_d = S_INS_WRITE;
				end else begin
					rd_addr = m_dec2[IW-1:0];
					m_d     = m_dec;
				end
			end
			S_INS_WRITE: begin
				ram_wr  = '{en: 1'b1, addr: k_q[IW-1:0],
					data: '{start: addr_q, len: size_q}};
				count_d = cnt_inc;
				if (peak_q < cnt_inc) begin
					peak_d = cnt_inc;
				end
				state_d = S_F_SUM;
			end
			S_L_CNT: begin
				alu_req    = '{a: lost_cnt_q, b: 32'd1, sub: 1'b0};
				lost_cnt_d = alu_rsp.res;
				status_d   = ffa_pkg::ST_LOST;
				state_d    = S_L_BYTES;
			end
			S_L_BYTES: begin
				alu_req      = '{a: lost_bytes_q, b: size_q, sub: 1'b0};
				lost_bytes_d = alu_rsp.res;
				state_d      = S_DONE;
			end
			S_RM_START: begin
				count_d = cnt_dec;
				if (k_inc == count_q) begin
					state_d = S_DONE;
				end else begin
					rd_addr = k_inc[IW-1:0];
					m_d     = k_q;
					state_d = S_RM_SHIFT;
				end
			end
			S_RM_SHIFT: begin
				// Move entry m+1 down to m, reading the one above it
				ram_wr = '{en: 1'b1, addr: m_q[IW-1:0], data: rd_data};
				if (m_inc == count_q) begin
					state_d = S_DONE;
				end else begin
					rd_addr = m_inc2[IW-1:0];
					m_d     = m_inc;
				end
			end
			S_DONE: begin
				done_d  = 1'b1;
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Hold control state and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			count_q      <= '0;
			peak_q       <= '0;
			lost_cnt_q   <= '0;
			lost_bytes_q <= '0;
			sum_q        <= '0;
			done_q       <= 1'b0;
		end else begin
			state_q      <= state_d;
			count_q      <= count_d;
			peak_q       <= peak_d;
			lost_cnt_q   <= lost_cnt_d;
			lost_bytes_q <= lost_bytes_d;
			sum_q        <= sum_d;
			done_q       <= done_d;
		end
	end

	// Advance the working registers
	always_ff @(posedge clk) begin
		op_q       <= op_d;
		addr_q     <= addr_d;
		size_q     <= size_d;
		k_q        <= k_d;
		m_q        <= m_d;
		cur_q      <= cur_d;
		prev_q     <= prev_d;
		tmp_q      <= tmp_d;
		res_addr_q <= res_addr_d;
		status_q   <= status_d;
		rm_q       <= rm_d;
	end

	assign busy             = (state_q != S_IDLE);
	assign done             = done_q;
	assign result_address   = res_addr_q;
	assign status           = status_q;
	assign free_total       = sum_q;
	assign entry_count      = count_q;
	assign peak_entry_count = peak_q;
	assign lost_count       = lost_cnt_q;
	assign lost_bytes       = lost_bytes_q;

	`FFA_ASSERT_NOW(a_done_not_busy, clk, arst_n, done, !busy)
	`FFA_ASSERT_NEXT(a_done_single, clk, arst_n, done, !done)
	`FFA_ASSERT_NEXT(a_start_busy, clk, arst_n, start && !busy, busy)
	`FFA_ASSERT_NOW(a_count_max, clk, arst_n, 1'b1, count_q <= ffa_pkg::MAX_CNT)
	`FFA_ASSERT_NOW(a_peak_bound, clk, arst_n, 1'b1, peak_q >= count_q)

endmodule

### sim/tb_top.sv
// Self-checking testbench for the first-fit free-region allocator.
`timescale 1ns / 100ps

module tb_top;

	// One command as driven on the ports.
	typedef struct packed {
		logic        op;
		logic [31:0] addr;
		logic [31:0] size;
		logic        round;
	} alloc_cmd_t;

	// One result as seen on the ports.
	typedef struct packed {
		logic [31:0]               addr;
		ffa_pkg::status_t          status;
		logic [31:0]               total;
		logic [ffa_pkg::CNT_W-1:0] cnt;
		logic [ffa_pkg::CNT_W-1:0] peak;
		logic [31:0]               lost_n;
		logic [31:0]               lost_b;
	} alloc_res_t;

	// Directed row: command plus an optional hand-written result.
	typedef struct packed {
		logic       given;
		alloc_cmd_t cmd;
		alloc_res_t res;
	} plan_row_t;

	// Block handed out by the allocator and not yet returned.
	typedef struct packed {
		logic [31:0] addr;
		logic [31:0] size;
	} block_t;

	localparam alloc_res_t  NO_RES    = '0;

	logic                         clk              = 1'b0;
	logic                         arst_n           = 1'b0;
	logic                         start            = 1'b0;
	logic                         operation        = ffa_pkg::OP_ALLOC;
	logic [31:0]                  block_address    = '0;
	logic [31:0]                  block_size       = '0;
	logic                         page_round       = 1'b0;
	logic                         busy;
	logic                         done;
	logic [31:0]                  result_address;
	logic [1:0]                   status;
	logic [31:0]                  free_total;
	logic [ffa_pkg::CNT_W-1:0]    entry_count;
	logic [ffa_pkg::CNT_W-1:0]    peak_entry_count;
	logic [31:0]                  lost_count;
	logic [31:0]                  lost_bytes;

	// Mirror of the region table
	logic [31:0] pool_base [ffa_pkg::MAX_REGIONS];
	logic [31:0] pool_len  [ffa_pkg::MAX_REGIONS];
	int unsigned pool_cnt   = 0;
	int unsigned pool_peak  = 0;
	logic [31:0] lost_frees = '0;
	logic [31:0] lost_sum   = '0;
	logic [31:0] free_sum   = '0;

	alloc_res_t  outcome_q [$];
	block_t      held_q [$];
	plan_row_t   plan [$];

	int          gap_pct     = 0;
	int          fault_count = 0;
	int          n_sent      = 0;
	int          n_checked   = 0;
	int          n_nofit     = 0;
	int          n_lost      = 0;

	first_fit_free_list_allocator_top dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.start            (start),
		.busy             (busy),
		.operation        (operation),
		.block_address    (block_address),
		.block_size       (block_size),
		.page_round       (page_round),
		.done             (done),
		.result_address   (result_address),
		.status           (status),
		.free_total       (free_total),
		.entry_count      (entry_count),
		.peak_entry_count (peak_entry_count),
		.lost_count       (lost_count),
		.lost_bytes       (lost_bytes)
	);

	// 20 ns clock
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Close the gap at entry k
	function automatic void close_entry(input int unsigned k);
		int unsigned m;
		if (pool_cnt == 0)
			return;
		pool_cnt--;
		for (m = k; m < pool_cnt; m++) begin
			pool_base[m] = pool_base[m + 1];
			pool_len[m]  = pool_len[m + 1];
		end
	endfunction

	// Apply one command to the mirror and return the result it should give
	function automatic alloc_res_t alloc_outcome(input alloc_cmd_t c);
		logic [31:0]      sz;
		logic [31:0]      ra;
		logic [31:0]      prev_end;
		logic [31:0]      blk_end;
		int unsigned      k;
		int unsigned      m;
		bit               prev_hit;
		ffa_pkg::status_t st;
		alloc_res_t       r;
		sz = c.size;
		if (c.round)
			sz = (sz + ffa_pkg::PAGE_ADD) & ffa_pkg::PAGE_MASK;
		ra = '0;
		k = 0;
		if (c.op == ffa_pkg::OP_ALLOC) begin
			// first fit, carve from the front
			while (k < pool_cnt && pool_len[k] < sz)
				k++;
			if (k < pool_cnt) begin
				ra = pool_base[k];
				pool_base[k] = pool_base[k] + sz;
				pool_len[k]  = pool_len[k] - sz;
				free_sum     = free_sum - sz;
				if (pool_len[k] == 32'd0)
					close_entry(k);
				st = ffa_pkg::ST_DONE;
			end else begin
				st = ffa_pkg::ST_NOFIT;
			end
		end else begin
			// find sorted slot, then try merges
			while (k < pool_cnt && pool_base[k] <= c.addr)
				k++;
			prev_hit = 1'b0;
			if (k > 0) begin
				prev_end = pool_base[k - 1] + pool_len[k - 1];
				prev_hit = (prev_end == c.addr);
			end
			blk_end = c.addr + sz;
			if (prev_hit) begin
				pool_len[k - 1] = pool_len[k - 1] + sz;
				free_sum = free_sum + sz;
				if (k < pool_cnt && blk_end == pool_base[k]) begin
					pool_len[k - 1] = pool_len[k - 1] + pool_len[k];
					close_entry(k);
				end
				st = ffa_pkg::ST_DONE;
			end else if (k < pool_cnt && blk_end == pool_base[k]) begin
				pool_base[k] = c.addr;
				pool_len[k]  = pool_len[k] + sz;
				free_sum     = free_sum + sz;
				st = ffa_pkg::ST_DONE;
			end else if (pool_cnt < ffa_pkg::MAX_REGIONS) begin
				for (m = pool_cnt; m > k; m--) begin
					pool_base[m] = pool_base[m - 1];
					pool_len[m]  = pool_len[m - 1];
				end
				pool_cnt++;
				if (pool_peak < pool_cnt)
					pool_peak = pool_cnt;
				pool_base[k] = c.addr;
				pool_len[k]  = sz;
				free_sum     = free_sum + sz;
				st = ffa_pkg::ST_DONE;
			end else begin
				lost_frees = lost_frees + 32'd1;
				lost_sum   = lost_sum + sz;
				st = ffa_pkg::ST_LOST;
			end
		end
		r.addr   = ra;
		r.status = st;
		r.total  = free_sum;
		r.cnt    = ffa_pkg::CNT_W'(pool_cnt);
		r.peak   = ffa_pkg::CNT_W'(pool_peak);
		r.lost_n = lost_frees;
		r.lost_b = lost_sum;
		return r;
	endfunction

	// Drive one command after an optional gap and wait for its transfer
	task automatic issue_cmd(input alloc_cmd_t c, input bit given, input alloc_res_t given_res);
		alloc_res_t  pred;
		logic [31:0] eff;
		int          gap;
		@(negedge clk);
		gap = 0;
		if ($urandom_range(0, 99) < gap_pct)
			gap = $urandom_range(1, 24);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		start         <= 1'b1;
		operation     <= c.op;
		block_address <= c.addr;
		block_size    <= c.size;
		page_round    <= c.round;
		do @(posedge clk); while (busy !== 1'b0);
		pred = alloc_outcome(c);
		outcome_q.push_back(given ? given_res : pred);
		n_sent++;
		if (pred.status == ffa_pkg::ST_NOFIT)
			n_nofit++;
		if (pred.status == ffa_pkg::ST_LOST)
			n_lost++;
		// remember handed-out blocks so they can be returned later
		eff = c.round ? ((c.size + ffa_pkg::PAGE_ADD) & ffa_pkg::PAGE_MASK) : c.size;
		if (c.op == ffa_pkg::OP_ALLOC && pred.status == ffa_pkg::ST_DONE && eff != 32'd0)
			held_q.push_back('{pred.addr, eff});
	endtask

	task automatic check_field(input string name, input logic [31:0] want,
		input logic [31:0] got);
		if (want !== got) begin
			fault_count++;
			if (fault_count <= 10)
				$display("mismatch on %s: expected %h, got %h", name, want, got);
		end
	endtask

	// Compare each result with the oldest expectation
	always @(posedge clk) begin
		alloc_res_t want;
		if (arst_n && done === 1'b1) begin
			if (outcome_q.size() == 0) begin
				fault_count++;
				if (fault_count <= 10)
					$display("result with nothing pending: address %h status %h",
						result_address, status);
			end else begin
				want = outcome_q.pop_front();
				n_checked++;
				check_field("result_address", want.addr, result_address);
				check_field("status", {30'b0, want.status}, {30'b0, status});
				check_field("free_total", want.total, free_total);
				check_field("entry_count", {19'b0, want.cnt}, {19'b0, entry_count});
				check_field("peak_entry_count", {19'b0, want.peak},
					{19'b0, peak_entry_count});
				check_field("lost_count", want.lost_n, lost_count);
				check_field("lost_bytes", want.lost_b, lost_bytes);
			end
		end
	end

	// Stimulus
	initial begin
		alloc_cmd_t c;
		int         phase;
		int         i;
		int         kind;
		int         idx;
		int         pct [3];
		pct = '{0, 64, 27};

		// directed rows; results typed in only where obvious
		plan.push_back('{1'b1, '{ffa_pkg::OP_ALLOC, 32'h0, 32'h0, 1'b0},
			'{32'h0, ffa_pkg::ST_NOFIT, 32'h0, ffa_pkg::CNT_W'(0), ffa_pkg::CNT_W'(0),
			32'h0, 32'h0}});
		plan.push_back('{1'b1, '{ffa_pkg::OP_ALLOC, 32'h0, 32'hffff_ffff, 1'b1},
			'{32'h0, ffa_pkg::ST_NOFIT, 32'h0, ffa_pkg::CNT_W'(0), ffa_pkg::CNT_W'(0),
			32'h0, 32'h0}});
		plan.push_back('{1'b1, '{ffa_pkg::OP_FREE, 32'h1000, 32'h1000, 1'b0},
			'{32'h0, ffa_pkg::ST_DONE, 32'h1000, ffa_pkg::CNT_W'(1), ffa_pkg::CNT_W'(1),
			32'h0, 32'h0}});
		plan.push_back('{1'b1, '{ffa_pkg::OP_ALLOC, 32'hffff_ffff, 32'h0, 1'b0},
			'{32'h1000, ffa_pkg::ST_DONE, 32'h1000, ffa_pkg::CNT_W'(1), ffa_pkg::CNT_W'(1),
			32'h0, 32'h0}});
		plan.push_back('{1'b1, '{ffa_pkg::OP_ALLOC, 32'h0, 32'h1001, 1'b0},
			'{32'h0, ffa_pkg::ST_NOFIT, 32'h1000, ffa_pkg::CNT_W'(1), ffa_pkg::CNT_W'(1),
			32'h0, 32'h0}});
		plan.push_back('{1'b0, '{ffa_pkg::OP_FREE, 32'h0, 32'h0, 1'b0}, NO_RES});
		plan.push_back('{1'b0, '{ffa_pkg::OP_ALLOC, 32'h0, 32'h0, 1'b0}, NO_RES});
		plan.push_back('{1'b0, '{ffa_pkg::OP_FREE, 32'h0, 32'h1000, 1'b0}, NO_RES});
		plan.push_back('{1'b0, '{ffa_pkg::OP_ALLOC, 32'h0, 32'h800, 1'b0}, NO_RES});
		plan.push_back('{1'b0, '{ffa_pkg::OP_FREE, 32'h0, 32'h800, 1'b0}, NO_RES});
		plan.push_back('{1'b0, '{ffa_pkg::OP_FREE, 32'h3000, 32'h1000, 1'b0}, NO_RES});
		plan.push_back('{1'b0, '{ffa_pkg::OP_FREE, 32'h2000, 32'h1000, 1'b0}, NO_RES});
		plan.push_back('{1'b0, '{ffa_pkg::OP_FREE, 32'h4000, 32'h10, 1'b1}, NO_RES});
		plan.push_back('{1'b0, '{ffa_pkg::OP_ALLOC, 32'h0, 32'h1, 1'b1}, NO_RES});
		plan.push_back('{1'b0, '{ffa_pkg::OP_FREE, 32'h0, 32'h1000, 1'b0}, NO_RES});
		plan.push_back('{1'b0, '{ffa_pkg::OP_FREE, 32'hffff_f000, 32'h1000, 1'b0}, NO_RES});
		plan.push_back('{1'b0, '{ffa_pkg::OP_FREE, 32'h1000, 32'h100, 1'b0}, NO_RES});
		plan.push_back('{1'b0, '{ffa_pkg::OP_FREE, 32'h1000, 32'h100, 1'b0}, NO_RES});
		plan.push_back('{1'b0, '{ffa_pkg::OP_ALLOC, 32'h0, 32'h5000, 1'b0}, NO_RES});
		plan.push_back('{1'b0, '{ffa_pkg::OP_FREE, 32'hffff_ffff, 32'hffff_ffff, 1'b0},
			NO_RES});
		plan.push_back('{1'b0, '{ffa_pkg::OP_ALLOC, 32'h0, 32'hffff_ffff, 1'b0}, NO_RES});
		plan.push_back('{1'b0, '{ffa_pkg::OP_FREE, 32'h9000, 32'hffff_f001, 1'b1}, NO_RES});
		plan.push_back('{1'b0, '{ffa_pkg::OP_FREE, 32'h4000_0000, 32'h0100_0000, 1'b0},
			NO_RES});

		// reset once
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		gap_pct = 27;
		foreach (plan[j])
			issue_cmd(plan[j].cmd, plan[j].given, plan[j].res);

		// random phases: mostly alloc/return traffic, some noise
		for (phase = 0; phase < 3; phase++) begin
			gap_pct = pct[phase];
			for (i = 0; i < 26; i++) begin
				if (phase == 1 && i == 13) begin
					// hold off until every pending result is in
					@(negedge clk);
					start <= 1'b0;
					while (outcome_q.size() != 0)
						@(posedge clk);
				end
				kind = $urandom_range(0, 99);
				c.op    = ffa_pkg::OP_ALLOC;
				c.addr  = $urandom;
				c.size  = $urandom_range(1, 32'h2000);
				c.round = 1'($urandom_range(0, 1));
				if (kind < 8) begin
					c.size = $urandom;
				end else if (kind < 35 || (kind < 70 && held_q.size() == 0)) begin
					// plain allocate as set above
				end else if (kind < 70) begin
					idx = $urandom_range(0, held_q.size() - 1);
					c.op    = ffa_pkg::OP_FREE;
					c.addr  = held_q[idx].addr;
					c.size  = held_q[idx].size;
					c.round = 1'b0;
					held_q.delete(idx);
				end else if (kind < 80) begin
					c.op   = ffa_pkg::OP_FREE;
					c.addr = 32'h1000_0000 + $urandom_range(0, 255) * 32'h40;
					c.size = $urandom_range(0, 32'h3f);
				end else if (kind < 85) begin
					c.size = '0;
				end else if (kind < 88) begin
					c.size  = (pool_cnt > 0) ? pool_len[0] : 32'd0;
					c.round = 1'b0;
				end else if (kind < 90) begin
					c.size  = 32'hffff_ffff;
					c.round = 1'b0;
				end else begin
					c.op    = 1'($urandom_range(0, 1));
					c.size  = $urandom;
				end
				issue_cmd(c, 1'b0, NO_RES);
			end
		end

		// drain, then let the block sit idle for a full scan time
		@(negedge clk);
		start <= 1'b0;
		while (outcome_q.size() != 0)
			@(posedge clk);
		repeat (2 * ffa_pkg::MAX_REGIONS + 16) @(posedge clk);

		$display("Ran %0d commands, %0d results checked: %0d no-fit allocates, %0d lost frees.",
			n_sent, n_checked, n_nofit, n_lost);
		$display("Table peaked at %0d of %0d entries; sender idle mixes of 0, 27 and 64 percent.",
			pool_peak, ffa_pkg::MAX_REGIONS);
		if (fault_count == 0)
			$display("tb_top OK");
		else
			$display("tb_top NOT OK");
		$finish;
	end

	// Watchdog
	initial begin
		repeat (30) #100_000_000;
		$display("timeout with %0d results pending", outcome_q.size());
		$display("tb_top NOT OK");
		$finish;
	end

endmodule
